// ----- sv/dirp_pkg.sv -----
// Shared types and constants for the decimal integer range parser.
// Used by every module of the block; no dependencies of its own.
package dirp_pkg;

  localparam int VALUE_WIDTH = 64;                 // signed range of the parsed value
  localparam int DATA_W      = 64;                 // width of value and range registers
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int SUM_W       = VALUE_WIDTH + 4;    // room for magnitude * 10 + digit
  localparam int CFG_IDX_W   = 8;
  localparam int FIFO_DEPTH  = 2;                  // power of two
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Largest magnitude for a negative and for a positive value.
  localparam logic [SUM_W-1:0] LIM_NEG = SUM_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [SUM_W-1:0] LIM_POS = LIM_NEG - SUM_W'(1);

  localparam logic [DATA_W-1:0] MIN_RESET = DATA_W'(1) << (DATA_W - 1);
  localparam logic [DATA_W-1:0] MAX_RESET = MIN_RESET - DATA_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 8'd1;

  localparam logic [1:0] CLS_TERM  = 2'd0;
  localparam logic [1:0] CLS_MINUS = 2'd1;
  localparam logic [1:0] CLS_DIGIT = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0]         cls;
    logic [DIGIT_W-1:0] digit;
  } tok_t;

endpackage

// ----- sv/dirp_front.sv -----
// Front end: takes one byte per beat and classifies it into a token.
// Depends on dirp_pkg.
module dirp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dirp_pkg::CHAR_W-1:0] in_char_code,
  output logic                        tok_vld,
  output dirp_pkg::tok_t              tok,
  input  logic                        tok_ready
);

  logic           tok_vld_r, tok_vld_nxt;
  dirp_pkg::tok_t tok_r, tok_nxt;
  logic           in_acc;

  assign in_ready = !tok_vld_r || tok_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    tok_nxt     = tok_r;
    tok_vld_nxt = tok_vld_r && !tok_ready;
    if (in_acc) begin
      tok_vld_nxt   = 1'b1;
      tok_nxt.digit = dirp_pkg::DIGIT_W'(in_char_code - dirp_pkg::CH_ZERO);
      if (in_char_code == dirp_pkg::CH_NUL) begin
        tok_nxt.cls = dirp_pkg::CLS_TERM;
      end else if (in_char_code == dirp_pkg::CH_MINUS) begin
        tok_nxt.cls = dirp_pkg::CLS_MINUS;
      end else if (in_char_code inside {[dirp_pkg::CH_ZERO:dirp_pkg::CH_NINE]}) begin
        tok_nxt.cls = dirp_pkg::CLS_DIGIT;
      end else begin
        tok_nxt.cls = dirp_pkg::CLS_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_vld = tok_vld_r;
  assign tok     = tok_r;

endmodule

// ----- sv/dirp_fifo.sv -----
// Short token queue between the front end and the back end.
// Depends on dirp_pkg for the token type and depth.
module dirp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_vld,
  output logic           wr_ready,
  input  dirp_pkg::tok_t wr_tok,
  output logic           rd_vld,
  output dirp_pkg::tok_t rd_tok,
  input  logic           rd_pop
);

  dirp_pkg::tok_t                 mem [dirp_pkg::FIFO_DEPTH];
  logic [dirp_pkg::PTR_W-1:0]     wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [dirp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           push, pop;

  assign wr_ready = cnt_r != dirp_pkg::CNT_W'(dirp_pkg::FIFO_DEPTH);
  assign rd_vld   = cnt_r != '0;
  assign rd_tok   = mem[rptr_r];
  assign push     = wr_vld && wr_ready;
  assign pop      = rd_pop && rd_vld;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + dirp_pkg::CNT_W'(push) - dirp_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_tok;
    end
  end

endmodule

// ----- sv/dirp_back.sv -----
// Back end: accumulates the magnitude, checks the range and holds the result.
// Also holds the min/max registers. Depends on dirp_pkg.
module dirp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [dirp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dirp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                           tok_vld,
  input  dirp_pkg::tok_t                 tok,
  output logic                           tok_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic signed [dirp_pkg::DATA_W-1:0] out_value
);

  logic [dirp_pkg::DATA_W-1:0]      min_r, max_r;
  logic [dirp_pkg::VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt, first_r, first_nxt, seen_r, seen_nxt, err_r, err_nxt;
  logic                             chk_vld_r, chk_vld_nxt, chk_ok_r, chk_ok_nxt;
  logic [dirp_pkg::DATA_W-1:0]      chk_val_r, chk_val_nxt;
  logic                             out_vld_r, out_vld_nxt, out_status_r, out_status_nxt;
  logic [dirp_pkg::DATA_W-1:0]      out_value_r, out_value_nxt;

  logic                         out_free, chk_free, is_term, ovf, in_range;
  logic [dirp_pkg::SUM_W-1:0]   mag_w, sum, limit;
  logic [dirp_pkg::DATA_W-1:0]  mag_ext, cand;

  always_comb begin
    out_free = !out_vld_r || out_ready;
    chk_free = !chk_vld_r || out_free;
    is_term  = tok.cls == dirp_pkg::CLS_TERM;
    tok_pop  = tok_vld && (!is_term || chk_free);

    // Times ten is done with two shifts and an add.
    mag_w = dirp_pkg::SUM_W'(mag_r);
    sum   = (mag_w << 3) + (mag_w << 1) + dirp_pkg::SUM_W'(tok.digit);
    limit = neg_r ? dirp_pkg::LIM_NEG : dirp_pkg::LIM_POS;
    ovf   = sum > limit;

    mag_ext = dirp_pkg::DATA_W'(mag_r);
    cand    = neg_r ? dirp_pkg::DATA_W'(0) - mag_ext : mag_ext;

    in_range = ($signed(min_r) <= $signed(chk_val_r)) &&
               ($signed(chk_val_r) <= $signed(max_r));
  end

  always_comb begin
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    first_nxt   = first_r;
    seen_nxt    = seen_r;
    err_nxt     = err_r;
    chk_vld_nxt = chk_vld_r && !out_free;
    chk_ok_nxt  = chk_ok_r;
    chk_val_nxt = chk_val_r;
    if (tok_pop) begin
      if (is_term) begin
        chk_vld_nxt = 1'b1;
        chk_ok_nxt  = !err_r && seen_r;
        chk_val_nxt = cand;
        mag_nxt     = '0;
        neg_nxt     = 1'b0;
        first_nxt   = 1'b1;
        seen_nxt    = 1'b0;
        err_nxt     = 1'b0;
      end else begin
        first_nxt = 1'b0;
        if (!err_r) begin
          case (tok.cls)
            dirp_pkg::CLS_MINUS: begin
              if (first_r) begin
                neg_nxt = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            dirp_pkg::CLS_DIGIT: begin
              if (ovf) begin
                err_nxt = 1'b1;
              end else begin
                mag_nxt  = sum[dirp_pkg::VALUE_WIDTH-1:0];
                seen_nxt = 1'b1;
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (chk_vld_r && out_free) begin
      out_vld_nxt = 1'b1;
      if (chk_ok_r && in_range) begin
        out_status_nxt = 1'b0;
        out_value_nxt  = chk_val_r;
      end else begin
        out_status_nxt = 1'b1;
        out_value_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= dirp_pkg::MIN_RESET;
      max_r <= dirp_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == dirp_pkg::REG_MIN_VALUE) begin
        min_r <= cfg_data;
      end else if (cfg_index == dirp_pkg::REG_MAX_VALUE) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r     <= '0;
      neg_r     <= 1'b0;
      first_r   <= 1'b1;
      seen_r    <= 1'b0;
      err_r     <= 1'b0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      first_r   <= first_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_ok_r     <= chk_ok_nxt;
    chk_val_r    <= chk_val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= dirp_pkg::LIM_NEG[dirp_pkg::VALUE_WIDTH-1:0])
    else $error("magnitude beyond the signed range");

  a_mag_frozen_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(tok_pop && is_term) |=> $stable(mag_r))
    else $error("magnitude changed after an error");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop && is_term |=> first_r && !seen_r && !err_r && !neg_r && chk_vld_r)
    else $error("terminator did not restart the parse");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r && out_free && !chk_ok_r |=> out_valid && out_status && out_value == '0)
    else $error("rejected result with nonzero value");

endmodule

// ----- sv/decimal_integer_range_parser.sv -----
// Top level of the decimal integer range parser: front end, token queue, back end.
// Depends on dirp_pkg, dirp_front, dirp_fifo and dirp_back.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_char_code[7:0]
//   out     | output    | out_valid / out_ready| out_status, out_value[63:0]
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[63:0]
//
// One byte is taken per cycle with both sides flowing; a terminator's result
// passes the front-end register, token queue, check register and output register.
// The accumulator's times-ten add and limit compare set the per-byte cycle.
// Reset is synchronous; it clears the parse state and loads the full signed range.
// Either side can stall alone: the two-entry token queue and the output register
// absorb back-pressure. cfg_ready is always high.
module decimal_integer_range_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dirp_pkg::CHAR_W-1:0]    in_char_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic signed [dirp_pkg::DATA_W-1:0] out_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dirp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dirp_pkg::DATA_W-1:0]    cfg_data
);

  logic           f_vld, f_ready, q_vld, q_pop;
  dirp_pkg::tok_t f_tok, q_tok;

  assign cfg_ready = 1'b1;

  dirp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .tok_vld      (f_vld),
    .tok          (f_tok),
    .tok_ready    (f_ready)
  );

  dirp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_vld   (f_vld),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_vld   (q_vld),
    .rd_tok   (q_tok),
    .rd_pop   (q_pop)
  );

  dirp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tok_vld    (q_vld),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value)
  );

endmodule
